// ===== rtl/lrupr_pkg.sv =====
package lrupr_pkg;

   localparam int DEF_MAX_FRAMES = 8;
   localparam int DEF_PAGE_BITS  = 16;

   // frame count register
   localparam int              CFG_W     = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

   // last-use stamps, use counter and fault total share this width
   localparam int STAMP_W = 32;

endpackage

// ===== rtl/lrupr_frame_store.sv =====
module lrupr_frame_store #(
   parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS,
   localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
   input  logic                          clock,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [PAGE_BITS-1:0]          rd_page,
   output logic [lrupr_pkg::STAMP_W-1:0] rd_stamp,
   input  logic                          wr_en,
   input  logic                          wr_page_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [PAGE_BITS-1:0]          wr_page,
   input  logic [lrupr_pkg::STAMP_W-1:0] wr_stamp
);

   logic [PAGE_BITS-1:0]          page_mem  [MAX_FRAMES];
   logic [lrupr_pkg::STAMP_W-1:0] stamp_mem [MAX_FRAMES];
   logic [PAGE_BITS-1:0]          rd_page_ff;
   logic [lrupr_pkg::STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_page_en) begin
            page_mem[wr_addr] <= wr_page;
         end
         stamp_mem[wr_addr] <= wr_stamp;
      end
      rd_page_ff  <= page_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_page  = rd_page_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement: each req_ transaction carries one page reference. The block walks the
// active frames (0 .. n-1, n taken from csr_wr_data, 0 acting as 1 and values above MAX_FRAMES
// acting as MAX_FRAMES) one frame per cycle through the single read port of the frame memory,
// checking for a hit, the first empty frame and the oldest stamp in the same pass. A reference
// then updates the frame in ST_UPDATE and holds its response in ST_RESULT until it is taken; a
// new request is taken the cycle after the response leaves, not before. req_stall is high
// from acceptance until the response is taken. fault_count and the stamp counter saturate at
// all ones, and stamp_overflow stays set from then on until reset.
module lru_page_replacement #(
   parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS,
   localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [PAGE_BITS-1:0]          req_page,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [IDX_W-1:0]              rsp_frame_index,
   output logic                          rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]          rsp_evicted_page,
   output logic [lrupr_pkg::STAMP_W-1:0] rsp_fault_count,
   output logic                          rsp_stamp_overflow,
   input  logic                          csr_wr_en,
   input  logic [lrupr_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SW    = lrupr_pkg::STAMP_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [lrupr_pkg::CFG_W-1:0] frames_ff, frames_in;
   logic [PAGE_BITS-1:0]        page_ff, page_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [CNT_W-1:0]            addr_ff, addr_in;
   logic                        eval_vld_ff, eval_vld_in;
   logic [CNT_W-1:0]            eval_idx_ff, eval_idx_in;
   logic                        hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic                        empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]            empty_idx_ff, empty_idx_in;
   logic [SW-1:0]               min_stamp_ff, min_stamp_in;
   logic [IDX_W-1:0]            min_idx_ff, min_idx_in;
   logic [PAGE_BITS-1:0]        min_page_ff, min_page_in;
   logic [MAX_FRAMES-1:0]       valid_ff, valid_in;
   logic [SW-1:0]               use_ctr_ff, use_ctr_in;
   logic [SW-1:0]               fault_ff, fault_in;
   logic                        ovf_ff, ovf_in;
   logic                        out_hit_ff, out_hit_in;
   logic [IDX_W-1:0]            out_idx_ff, out_idx_in;
   logic                        out_evict_ff, out_evict_in;
   logic [PAGE_BITS-1:0]        out_evict_page_ff, out_evict_page_in;

   logic [PAGE_BITS-1:0] rd_page;
   logic [SW-1:0]        rd_stamp;
   logic [31:0]          n_wide;
   logic [IDX_W-1:0]     eval_pos;
   logic [IDX_W-1:0]     pos;
   logic [SW-1:0]        new_stamp;
   logic                 wr_en;
   logic                 wr_page_en;

   // clamp the frame count into 1 .. MAX_FRAMES
   always_comb begin
      n_wide = 32'(frames_ff);
      if (n_wide == 32'd0) begin
         n_wide = 32'd1;
      end else if (n_wide > 32'(MAX_FRAMES)) begin
         n_wide = 32'(MAX_FRAMES);
      end
   end

   assign eval_pos  = eval_idx_ff[IDX_W-1:0];
   assign pos       = hit_found_ff ? hit_idx_ff : (empty_found_ff ? empty_idx_ff : min_idx_ff);
   assign new_stamp = (use_ctr_ff != '1) ? use_ctr_ff + 1'b1 : use_ctr_ff;
   assign wr_en      = (state_ff == ST_UPDATE);
   assign wr_page_en = !hit_found_ff;

   lrupr_frame_store #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_store (
      .clock      (clock),
      .rd_addr    (addr_ff[IDX_W-1:0]),
      .rd_page    (rd_page),
      .rd_stamp   (rd_stamp),
      .wr_en      (wr_en),
      .wr_page_en (wr_page_en),
      .wr_addr    (pos),
      .wr_page    (page_ff),
      .wr_stamp   (new_stamp)
   );

   always_comb begin
      state_in          = state_ff;
      frames_in         = frames_ff;
      page_in           = page_ff;
      n_in              = n_ff;
      addr_in           = addr_ff;
      eval_vld_in       = eval_vld_ff;
      eval_idx_in       = eval_idx_ff;
      hit_found_in      = hit_found_ff;
      hit_idx_in        = hit_idx_ff;
      empty_found_in    = empty_found_ff;
      empty_idx_in      = empty_idx_ff;
      min_stamp_in      = min_stamp_ff;
      min_idx_in        = min_idx_ff;
      min_page_in       = min_page_ff;
      valid_in          = valid_ff;
      use_ctr_in        = use_ctr_ff;
      fault_in          = fault_ff;
      ovf_in            = ovf_ff;
      out_hit_in        = out_hit_ff;
      out_idx_in        = out_idx_ff;
      out_evict_in      = out_evict_ff;
      out_evict_page_in = out_evict_page_ff;

      if (csr_wr_en) begin
         frames_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in        = req_page;
               n_in           = CNT_W'(n_wide);
               addr_in        = '0;
               eval_vld_in    = 1'b0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of frame addr_ff is issued now, frame eval_idx_ff is checked now
            eval_vld_in = (addr_ff < n_ff);
            eval_idx_in = addr_ff;
            addr_in     = addr_ff + 1'b1;
            if (eval_vld_ff) begin
               if (!hit_found_ff && valid_ff[eval_pos] && rd_page == page_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = eval_pos;
               end
               if (!empty_found_ff && !valid_ff[eval_pos]) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = eval_pos;
               end
               // strict less keeps the lowest index on a tie
               if (eval_idx_ff == '0 || rd_stamp < min_stamp_ff) begin
                  min_stamp_in = rd_stamp;
                  min_idx_in   = eval_pos;
                  min_page_in  = rd_page;
               end
               if (eval_idx_ff == n_ff - 1'b1) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            use_ctr_in = new_stamp;
            if (new_stamp == '1) begin
               ovf_in = 1'b1;
            end
            if (!hit_found_ff) begin
               valid_in[pos] = 1'b1;
               if (fault_ff != '1) begin
                  fault_in = fault_ff + 1'b1;
               end
            end
            out_hit_in        = hit_found_ff;
            out_idx_in        = pos;
            out_evict_in      = !hit_found_ff && !empty_found_ff;
            out_evict_page_in = (!hit_found_ff && !empty_found_ff) ? min_page_ff : '0;
            state_in          = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         frames_ff <= lrupr_pkg::CFG_RESET;
         valid_ff  <= '0;
         use_ctr_ff <= '0;
         fault_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         frames_ff <= frames_in;
         valid_ff  <= valid_in;
         use_ctr_ff <= use_ctr_in;
         fault_ff  <= fault_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff           <= page_in;
      n_ff              <= n_in;
      addr_ff           <= addr_in;
      eval_vld_ff       <= eval_vld_in;
      eval_idx_ff       <= eval_idx_in;
      hit_found_ff      <= hit_found_in;
      hit_idx_ff        <= hit_idx_in;
      empty_found_ff    <= empty_found_in;
      empty_idx_ff      <= empty_idx_in;
      min_stamp_ff      <= min_stamp_in;
      min_idx_ff        <= min_idx_in;
      min_page_ff       <= min_page_in;
      out_hit_ff        <= out_hit_in;
      out_idx_ff        <= out_idx_in;
      out_evict_ff      <= out_evict_in;
      out_evict_page_ff <= out_evict_page_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESULT);
   assign rsp_hit            = out_hit_ff;
   assign rsp_frame_index    = out_idx_ff;
   assign rsp_evicted_valid  = out_evict_ff;
   assign rsp_evicted_page   = out_evict_page_ff;
   assign rsp_fault_count    = fault_ff;
   assign rsp_stamp_overflow = ovf_ff;

endmodule

// ===== dv/lru_page_replacement_test.sv =====
`timescale 1ns / 100ps

typedef struct {
   logic        hit;
   logic [2:0]  frame_index;
   logic        evicted_valid;
   logic [15:0] evicted_page;
   logic [31:0] fault_count;
   logic        stamp_overflow;
} lru_result_type;

class lru_scoreboard;
   bit [3:0]       frames_cfg;
   bit [15:0]      frame_page[8];
   bit             frame_full[8];
   bit [31:0]      frame_stamp[8];
   bit [31:0]      use_count;
   bit [31:0]      faults;
   bit             overflow;
   lru_result_type expected_q[$];
   int             errors;

   function new();
      frames_cfg = lrupr_pkg::CFG_RESET;
      for (int i = 0; i < 8; i++) begin
         frame_page[i]  = '0;
         frame_full[i]  = 1'b0;
         frame_stamp[i] = '0;
      end
      use_count = '0;
      faults    = '0;
      overflow  = 1'b0;
      errors    = 0;
   endfunction

   task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   function void set_frames(bit [3:0] value);
      frames_cfg = value;
   endfunction

   function int active_frames();
      if (frames_cfg == 0) begin
         return 1;
      end
      if (frames_cfg > 8) begin
         return 8;
      end
      return int'(frames_cfg);
   endfunction

   // stamp counter saturates at all ones and latches the overflow flag
   function bit [31:0] next_stamp();
      if (use_count != '1) begin
         use_count++;
      end
      if (use_count == '1) begin
         overflow = 1'b1;
      end
      return use_count;
   endfunction

   function void note_request(bit [15:0] page);
      lru_result_type r;
      int             n;
      int             slot;
      bit             hit;
      bit             free_found;
      bit [31:0]      oldest;
      n          = active_frames();
      slot       = 0;
      hit        = 1'b0;
      free_found = 1'b0;
      r.evicted_valid = 1'b0;
      r.evicted_page  = '0;
      for (int i = 0; i < n; i++) begin
         if (!hit && frame_full[i] && frame_page[i] == page) begin
            hit  = 1'b1;
            slot = i;
         end
      end
      if (hit) begin
         frame_stamp[slot] = next_stamp();
      end else begin
         for (int i = 0; i < n; i++) begin
            if (!free_found && !frame_full[i]) begin
               free_found = 1'b1;
               slot       = i;
            end
         end
         if (!free_found) begin
            // oldest stamp wins, lowest frame on a tie
            oldest = frame_stamp[0];
            slot   = 0;
            for (int i = 1; i < n; i++) begin
               if (frame_stamp[i] < oldest) begin
                  oldest = frame_stamp[i];
                  slot   = i;
               end
            end
            r.evicted_valid = 1'b1;
            r.evicted_page  = frame_page[slot];
         end
         if (faults != '1) begin
            faults++;
         end
         frame_page[slot]  = page;
         frame_full[slot]  = 1'b1;
         frame_stamp[slot] = next_stamp();
      end
      r.hit            = hit;
      r.frame_index    = slot[2:0];
      r.fault_count    = faults;
      r.stamp_overflow = overflow;
      expected_q.push_back(r);
   endfunction

   task check_response(lru_result_type got);
      lru_result_type want;
      if (expected_q.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit) begin
         report($sformatf("hit got %b want %b", got.hit, want.hit));
      end
      if (got.frame_index !== want.frame_index) begin
         report($sformatf("frame_index got %0d want %0d", got.frame_index, want.frame_index));
      end
      if (got.evicted_valid !== want.evicted_valid) begin
         report($sformatf("evicted_valid got %b want %b", got.evicted_valid,
                          want.evicted_valid));
      end
      if (got.evicted_page !== want.evicted_page) begin
         report($sformatf("evicted_page got %h want %h", got.evicted_page,
                          want.evicted_page));
      end
      if (got.fault_count !== want.fault_count) begin
         report($sformatf("fault_count got %0d want %0d", got.fault_count,
                          want.fault_count));
      end
      if (got.stamp_overflow !== want.stamp_overflow) begin
         report($sformatf("stamp_overflow got %b want %b", got.stamp_overflow,
                          want.stamp_overflow));
      end
   endtask
endclass

module lru_page_replacement_test;

   localparam int PAGE_W      = lrupr_pkg::DEF_PAGE_BITS;
   localparam int IDX_W       = $clog2(lrupr_pkg::DEF_MAX_FRAMES);
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 16;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [PAGE_W-1:0]             req_page = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_hit;
   logic [IDX_W-1:0]              rsp_frame_index;
   logic                          rsp_evicted_valid;
   logic [PAGE_W-1:0]             rsp_evicted_page;
   logic [lrupr_pkg::STAMP_W-1:0] rsp_fault_count;
   logic                          rsp_stamp_overflow;
   logic                          csr_wr_en = 1'b0;
   logic [lrupr_pkg::CFG_W-1:0]   csr_wr_data = '0;

   lru_scoreboard sb = new();
   int            cycles = 0;
   bit            calm = 1'b0;
   bit [15:0]     page_pool[12];

   lru_page_replacement u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_page           (req_page),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_count    (rsp_fault_count),
      .rsp_stamp_overflow (rsp_stamp_overflow),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      lru_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.hit            = rsp_hit;
         got.frame_index    = rsp_frame_index;
         got.evicted_valid  = rsp_evicted_valid;
         got.evicted_page   = rsp_evicted_page;
         got.fault_count    = rsp_fault_count;
         got.stamp_overflow = rsp_stamp_overflow;
         sb.check_response(got);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // receiver back-pressure: quiet stretches mixed with short and long stalls
   initial begin
      int k;
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end else begin
            k = pick_gap();
            rsp_stall <= (k != 0);
            repeat ((k == 0) ? $urandom_range(1, 4) : k) @(posedge clock);
         end
      end
   end

   task automatic send_page(bit [15:0] page);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page  <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(page);
   endtask

   // frame count changes only once every reference has been answered
   task automatic write_frames(bit [3:0] value);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_frames(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_list(bit [15:0] pages[$]);
      foreach (pages[i]) begin
         send_page(pages[i]);
      end
   endtask

   function automatic bit [15:0] pick_page(int n);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return page_pool[$urandom_range(0, n + 2)];
      end
      if (r < 90) begin
         return 16'($urandom);
      end
      if (r < 95) begin
         return 16'hFFFF;
      end
      return 16'h0000;
   endfunction

   initial begin
      bit [3:0] cfg;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset frame count: fill, hit, then evict the oldest
      send_list('{16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hA5A5, 16'h0000,
                  16'h5A5A, 16'hFFFF});
      // shrink: frame 2 keeps its page but is out of play
      write_frames(4'd2);
      send_list('{16'h5A5A, 16'h0000, 16'h8001});
      // above the frame limit acts as all frames, old frame 2 visible again
      write_frames(4'd15);
      send_list('{16'h5A5A, 16'h1234, 16'hFFFF, 16'h0000});
      // zero acts as one frame
      write_frames(4'd0);
      send_list('{16'h0000, 16'h0001, 16'h0001});
      write_frames(4'd1);
      send_list('{16'h0001, 16'hFFFE});
      write_frames(4'd8);
      send_list('{16'h0000, 16'h5A5A, 16'h0001, 16'hFFFE, 16'h7FFF});

      foreach (page_pool[i]) begin
         page_pool[i] = 16'($urandom);
      end
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: cfg = 4'd1;
            1: cfg = 4'd8;
            default: cfg = 4'($urandom_range(0, 15));
         endcase
         write_frames(cfg);
         calm = ($urandom_range(0, 3) == 0);
         // keep part of the working set so shrunk frames come back into play
         repeat (4) page_pool[$urandom_range(0, 11)] = 16'($urandom);
         repeat (50) send_page(pick_page(sb.active_frames()));
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
